/* rtl/fcm_pkg.sv */
package fcm_pkg;

    // Table depth and derived widths.
    localparam int MAX_TAPS  = 256;
    localparam int ADDR_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W     = $clog2(MAX_TAPS + 1);

    // Fixed field widths.
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int IDX_W     = 8;
    localparam int TAPCNT_W  = 9;
    localparam int OUT_SHIFT = 16;

    // Item kinds carried in tuser.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctrl;

endpackage

/* rtl/fcm_ram.sv */
module fcm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fcm_mac.sv */
module fcm_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fcm_pkg::t_mac_ctrl                  i_ctrl,
    input  logic signed [fcm_pkg::DATA_W-1:0]   i_coef,
    input  logic signed [fcm_pkg::DATA_W-1:0]   i_hist,
    output logic                                o_busy,
    output logic [fcm_pkg::ACC_W-1:0]           o_acc
);

    logic signed [fcm_pkg::ACC_W-1:0] w_prod;
    logic        [fcm_pkg::ACC_W-1:0] r_prod;
    logic                             r_prod_vld;
    logic        [fcm_pkg::ACC_W-1:0] r_acc;

    // Both operands are signed, so they sign-extend to the full product width.
    assign w_prod = i_coef * i_hist;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_ctrl.valid;
            if (i_ctrl.clear) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_acc + r_prod;
            end
        end
    end

    assign o_busy = r_prod_vld;
    assign o_acc  = r_acc;

endmodule

/* rtl/fir_filter_circular_mac_unit.sv */
// A load item is taken while the sequencer rests and leaves it at rest. A sample item steps
// the sequencer through run (skipped when the tap count in use is zero), drain and finish,
// where the result is registered; no new item is taken until then. A single shared
// multiply-accumulate visits one tap per cycle over the coefficient and history RAMs.
// Reset (synchronous, active low) sets the tap count to 1, the write position to 0, arms
// priming and clears the history valid bits; the RAM contents themselves are not cleared.
module fir_filter_circular_mac_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Input items.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata from bit 0 up: coef_index[7:0], coef_value[39:8], sample[71:40]
    input  logic [71:0]                         i_s_axis_tdata,
    // tuser: cmd[0]
    input  logic                                i_s_axis_tuser,

    // Result items.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata from bit 0 up: filtered[31:0]
    output logic [31:0]                         o_m_axis_tdata,

    // Tap count register write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fcm_pkg::TAPCNT_W-1:0]        i_cfg_data
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam int AW = fcm_pkg::ADDR_W;
    localparam int CW = fcm_pkg::CNT_W;
    localparam int DW = fcm_pkg::DATA_W;

    // Unpacked input fields.
    logic                          w_cmd;
    logic [fcm_pkg::IDX_W-1:0]     w_coef_index;
    logic [DW-1:0]                 w_coef_value;
    logic [DW-1:0]                 w_sample;

    assign w_cmd        = i_s_axis_tuser;
    assign w_coef_index = i_s_axis_tdata[7:0];
    assign w_coef_value = i_s_axis_tdata[39:8];
    assign w_sample     = i_s_axis_tdata[71:40];

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [fcm_pkg::TAPCNT_W-1:0]  r_tap_count;
    logic [AW-1:0]                 r_wp;
    logic                          r_prime;
    logic                          r_prime_run;
    logic [DW-1:0]                 r_sample;
    logic [AW-1:0]                 r_k;
    logic [AW-1:0]                 r_pos;
    logic                          r_rd_vld;
    logic                          r_subst;
    logic                          r_hvld_q;
    logic [fcm_pkg::MAX_TAPS-1:0]  r_hist_vld;
    logic                          r_out_vld;
    logic [DW-1:0]                 r_out_data;

    logic                          w_accept;
    logic                          w_load;
    logic                          w_smp;
    logic [CW-1:0]                 w_taps;
    logic [AW-1:0]                 w_wp_eff;
    logic [AW-1:0]                 w_wp_after;
    logic [CW-1:0]                 w_pos_inc;
    logic [AW-1:0]                 w_pos_next;
    logic                          w_last;
    logic                          w_out_load;

    logic                          w_coef_we;
    logic [AW-1:0]                 w_coef_waddr;
    logic                          w_hist_we;
    logic [AW-1:0]                 w_hist_waddr;
    logic [DW-1:0]                 w_hist_wdata;
    logic [DW-1:0]                 w_coef_q;
    logic [DW-1:0]                 w_hist_q;
    logic [DW-1:0]                 w_hist_op;

    fcm_pkg::t_mac_ctrl            w_mac_ctrl;
    logic                          w_mac_busy;
    logic [fcm_pkg::ACC_W-1:0]     w_acc;

    // Items are taken only while the sequencer rests; the output register lets a
    // finished result wait while the next item is accepted.
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load   = w_accept && (w_cmd == fcm_pkg::CMD_LOAD);
    assign w_smp    = w_accept && (w_cmd == fcm_pkg::CMD_SAMPLE);

    // Tap counts above the table depth saturate to the depth.
    assign w_taps = (32'(r_tap_count) > 32'(fcm_pkg::MAX_TAPS)) ?
                    CW'(fcm_pkg::MAX_TAPS) : CW'(r_tap_count);

    // A write position left beyond a lowered tap count restarts at the first slot.
    assign w_wp_eff = (CW'(r_wp) >= w_taps) ? '0 : r_wp;

    // After a sample the write position steps backward, wrapping to the last active slot,
    // so that coefficient 0 always meets the newest sample.
    assign w_wp_after = (r_wp == '0) ? AW'(w_taps - CW'(1)) : (r_wp - AW'(1));

    // The history read position walks forward from the newest sample and wraps at the
    // tap count.
    assign w_pos_inc  = CW'(r_pos) + CW'(1);
    assign w_pos_next = (w_pos_inc >= w_taps) ? '0 : AW'(w_pos_inc);
    assign w_last     = ((CW'(r_k) + CW'(1)) == w_taps);

    // Coefficient RAM: written by load items whose index falls inside the table.
    assign w_coef_we    = w_load && (32'(w_coef_index) < 32'(fcm_pkg::MAX_TAPS));
    assign w_coef_waddr = AW'(w_coef_index);

    // History RAM: a normal sample is written at its slot as it is accepted. A priming
    // sample instead is written into every slot the pass visits, and every tap of that
    // pass uses the sample itself rather than what the RAM returns.
    always_comb begin
        w_hist_we    = 1'b0;
        w_hist_waddr = w_wp_eff;
        w_hist_wdata = w_sample;
        if (r_state == ST_RUN) begin
            w_hist_we    = r_prime_run;
            w_hist_waddr = r_pos;
            w_hist_wdata = r_sample;
        end else if (w_smp && (w_taps != '0) && !r_prime) begin
            w_hist_we = 1'b1;
        end
    end

    fcm_ram #(
        .DEPTH (fcm_pkg::MAX_TAPS),
        .WIDTH (DW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_waddr),
        .i_wdata (w_coef_value),
        .i_raddr (r_k),
        .o_rdata (w_coef_q)
    );

    fcm_ram #(
        .DEPTH (fcm_pkg::MAX_TAPS),
        .WIDTH (DW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_hist_q)
    );

    // History slots never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (w_hist_we) begin
            r_hist_vld[w_hist_waddr] <= 1'b1;
        end
    end

    // Read-side flags, registered alongside the RAM read data.
    always_ff @(posedge i_clk) begin
        r_hvld_q <= r_hist_vld[r_pos];
        r_subst  <= r_prime_run;
    end

    assign w_hist_op = r_subst ? r_sample : (r_hvld_q ? w_hist_q : '0);

    // The accumulator is cleared as a sample is accepted; with zero taps nothing is
    // issued, so the result comes out as zero.
    assign w_mac_ctrl.clear = w_smp;
    assign w_mac_ctrl.valid = r_rd_vld;

    fcm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mac_ctrl),
        .i_coef  (w_coef_q),
        .i_hist  (w_hist_op),
        .o_busy  (w_mac_busy),
        .o_acc   (w_acc)
    );

    assign w_out_load = (r_state == ST_FINISH) && (!r_out_vld || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_smp) begin
                    n_state = (w_taps == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !w_mac_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap_count <= fcm_pkg::TAPCNT_W'(1);
            r_wp        <= '0;
            r_prime     <= 1'b1;
            r_prime_run <= 1'b0;
            r_k         <= '0;
            r_pos       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_RUN);

            if (i_cfg_valid && o_cfg_ready) begin
                r_tap_count <= i_cfg_data;
            end

            if (w_load) begin
                r_wp    <= '0;
                r_prime <= 1'b1;
            end else if (w_smp && (w_taps != '0)) begin
                r_wp        <= w_wp_eff;
                r_prime     <= 1'b0;
                r_prime_run <= r_prime;
                r_k         <= '0;
                r_pos       <= w_wp_eff;
            end

            if (r_state == ST_RUN) begin
                r_k   <= r_k + AW'(1);
                r_pos <= w_pos_next;
                if (w_last) begin
                    r_wp        <= w_wp_after;
                    r_prime_run <= 1'b0;
                end
            end

            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_smp) begin
            r_sample <= w_sample;
        end
        if (w_out_load) begin
            r_out_data <= w_acc[fcm_pkg::OUT_SHIFT + DW - 1:fcm_pkg::OUT_SHIFT];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

/* test/tb_fir_filter_circular_mac_unit.sv */
module tb_fir_filter_circular_mac_unit;

    // Receiver hold-off length, in cycles, used once to back the filter up.
    localparam int LONG_HOLD = 2000;

    // One input item as it is split over tuser and tdata.
    typedef struct packed {
        logic                       cmd;
        logic [fcm_pkg::IDX_W-1:0]  coef_index;
        logic [fcm_pkg::DATA_W-1:0] coef_value;
        logic [fcm_pkg::DATA_W-1:0] sample;
    } t_filter_item;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_s_axis_tvalid = 1'b0;
    logic                         o_s_axis_tready;
    // tdata from bit 0 up: coef_index[7:0], coef_value[39:8], sample[71:40]
    logic [71:0]                  i_s_axis_tdata = '0;
    // tuser: cmd[0]
    logic                         i_s_axis_tuser = 1'b0;
    logic                         o_m_axis_tvalid;
    logic                         i_m_axis_tready = 1'b0;
    // tdata from bit 0 up: filtered[31:0]
    logic [31:0]                  o_m_axis_tdata;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [fcm_pkg::TAPCNT_W-1:0] i_cfg_data = '0;

    // Stimulus bookkeeping.
    t_filter_item                 pending_items[$];
    t_filter_item                 next_item;
    logic [fcm_pkg::DATA_W-1:0]   expected_filtered[$];
    int                           queued_items = 0;
    int                           accepted_items = 0;
    int                           error_count = 0;
    logic                         input_taken = 1'b0;

    // Idling rates in percent, and the long receiver hold-off.
    int                           sender_idle_pct = 0;
    int                           receiver_idle_pct = 0;
    int                           hold_requests = 0;
    int                           holds_served = 0;
    int                           hold_left = 0;

    // Filter state as the testbench predicts it; the history starts out as zeros.
    logic [fcm_pkg::TAPCNT_W-1:0]      tap_count_reg = fcm_pkg::TAPCNT_W'(1);
    logic signed [fcm_pkg::DATA_W-1:0] coef_table[fcm_pkg::MAX_TAPS];
    logic signed [fcm_pkg::DATA_W-1:0] history[fcm_pkg::MAX_TAPS] = '{default: '0};
    int                                write_pos = 0;
    logic                              prime_armed = 1'b1;

    fir_filter_circular_mac_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A load writes the coefficient and restarts the history with priming armed.
    function automatic void load_coefficient(input logic [fcm_pkg::IDX_W-1:0] index,
                                             input logic [fcm_pkg::DATA_W-1:0] value);
        coef_table[index] = value;
        write_pos = 0;
        prime_armed = 1'b1;
    endfunction

    // Runs one sample through the filter and returns the expected output word.
    function automatic logic [fcm_pkg::DATA_W-1:0] filter_sample(
            input logic [fcm_pkg::DATA_W-1:0] value);
        int                               taps;
        int                               pos;
        logic [fcm_pkg::ACC_W-1:0]        tap_sum;
        logic signed [fcm_pkg::ACC_W-1:0] product;
        taps = (tap_count_reg > fcm_pkg::MAX_TAPS) ? fcm_pkg::MAX_TAPS : int'(tap_count_reg);
        if (taps == 0) begin
            return '0;
        end
        if (prime_armed) begin
            for (int k = 0; k < taps; k++) begin
                history[k] = value;
            end
            prime_armed = 1'b0;
        end
        if (write_pos >= taps) begin
            write_pos = 0;
        end
        history[write_pos] = value;
        // Coefficient 0 meets the newest sample; older samples sit at rising positions.
        tap_sum = '0;
        pos = write_pos;
        for (int k = 0; k < taps; k++) begin
            product = coef_table[k] * history[pos];
            tap_sum = tap_sum + product;
            pos = (pos + 1 >= taps) ? 0 : pos + 1;
        end
        write_pos = (write_pos == 0) ? taps - 1 : write_pos - 1;
        return tap_sum[fcm_pkg::OUT_SHIFT +: fcm_pkg::DATA_W];
    endfunction

    function automatic logic [fcm_pkg::DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return fcm_pkg::DATA_W'($urandom_range(0, 2000)) - fcm_pkg::DATA_W'(1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_load(input logic [fcm_pkg::IDX_W-1:0] index,
                                      input logic [fcm_pkg::DATA_W-1:0] value);
        t_filter_item item;
        item.cmd = fcm_pkg::CMD_LOAD;
        item.coef_index = index;
        item.coef_value = value;
        item.sample = $urandom;
        pending_items.push_back(item);
        queued_items++;
    endfunction

    function automatic void push_sample(input logic [fcm_pkg::DATA_W-1:0] value);
        t_filter_item item;
        item.cmd = fcm_pkg::CMD_SAMPLE;
        item.coef_index = fcm_pkg::IDX_W'($urandom);
        item.coef_value = $urandom;
        item.sample = value;
        pending_items.push_back(item);
        queued_items++;
    endfunction

    // Waits until every item is in and every result is out, then lets a load or a
    // zero-tap sample that is still in flight finish.
    task automatic settle_idle();
        while (accepted_items != queued_items || expected_filtered.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_tap_count(input logic [fcm_pkg::TAPCNT_W-1:0] value);
        settle_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        tap_count_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sender: a new item goes out once the previous one has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || input_taken) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                next_item = pending_items.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {next_item.sample, next_item.coef_value,
                                   next_item.coef_index};
                i_s_axis_tuser <= next_item.cmd;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted down here.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Monitor: predicts on every accepted input item and checks every result.
    always @(posedge i_clk) begin
        input_taken <= i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                accepted_items++;
                if (i_s_axis_tuser == fcm_pkg::CMD_LOAD) begin
                    load_coefficient(i_s_axis_tdata[7:0], i_s_axis_tdata[39:8]);
                end else begin
                    expected_filtered.push_back(filter_sample(i_s_axis_tdata[71:40]));
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_filtered.size() == 0) begin
                    $error("filtered: no result expected, got %0d", $signed(o_m_axis_tdata));
                    error_count++;
                end else if (o_m_axis_tdata !== expected_filtered[0]) begin
                    $error("filtered: expected %0d, got %0d",
                           $signed(expected_filtered[0]), $signed(o_m_axis_tdata));
                    error_count++;
                    void'(expected_filtered.pop_front());
                end else begin
                    void'(expected_filtered.pop_front());
                end
            end
        end
    end

    initial begin
        #(10 * 3_000_000);
        $display("FAIL");
        $finish;
    end

    initial begin
        int                           phase;
        int                           phase_len;
        logic                         hold_done;
        logic                         long_hold;
        logic [fcm_pkg::TAPCNT_W-1:0] taps;

        hold_done = 1'b0;
        sender_idle_pct = 38;
        receiver_idle_pct = 63;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single tap from reset: extreme coefficients against extreme samples,
        // the first sample priming the history.
        push_load(8'd0, 32'h7FFF_FFFF);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'h0000_0000);
        push_sample(32'hFFFF_FFFF);
        push_load(8'd0, 32'h8000_0000);
        push_sample(32'h8000_0000);
        push_sample(32'h7FFF_FFFF);
        push_load(8'd255, 32'hFFFF_FFFF);
        push_load(8'd1, 32'h0001_0000);
        push_load(8'd2, 32'hFFFF_0000);
        push_load(8'd3, 32'h0000_8000);
        push_load(8'd0, 32'h0001_0000);
        push_sample(32'd12345);

        // Zero taps: the output is zero and the history is left alone.
        write_tap_count(fcm_pkg::TAPCNT_W'(0));
        push_sample(32'hAAAA_5555);
        push_sample(32'h5555_AAAA);

        // Four taps with distinct samples show which coefficient meets which sample.
        write_tap_count(fcm_pkg::TAPCNT_W'(4));
        push_sample(32'd100);
        push_sample(32'd200);
        push_sample(32'd300);
        push_sample(32'd400);
        push_sample(32'd500);

        // Lowering the tap count leaves the write position past the new end.
        write_tap_count(fcm_pkg::TAPCNT_W'(2));
        push_sample(32'd600);

        // Fill the whole coefficient table so that any tap count may be used.
        for (int i = 0; i < fcm_pkg::MAX_TAPS; i++) begin
            push_load(fcm_pkg::IDX_W'(i), rand_word());
        end

        phase = 0;
        while (queued_items < 900) begin
            if (queued_items < 450) begin
                sender_idle_pct = 38;
                receiver_idle_pct = 63;
            end else if (queued_items < 700) begin
                sender_idle_pct = 63;
                receiver_idle_pct = 38;
            end else begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            long_hold = !hold_done && queued_items >= 700;
            // A few phases run the full table, including counts that saturate.
            if (phase == 2) begin
                taps = fcm_pkg::TAPCNT_W'(fcm_pkg::MAX_TAPS);
            end else if (phase == 5) begin
                taps = '1;
            end else if (phase == 9) begin
                taps = fcm_pkg::TAPCNT_W'(fcm_pkg::MAX_TAPS + 1);
            end else if (long_hold) begin
                taps = fcm_pkg::TAPCNT_W'(3);
            end else begin
                case ($urandom_range(0, 9))
                    0:       taps = '0;
                    1, 2:    taps = fcm_pkg::TAPCNT_W'($urandom_range(9, 40));
                    default: taps = fcm_pkg::TAPCNT_W'($urandom_range(1, 8));
                endcase
            end
            write_tap_count(taps);
            phase_len = (taps >= fcm_pkg::MAX_TAPS) ? 12 : $urandom_range(20, 50);
            if (long_hold) begin
                // The result side stops for a long stretch while items keep coming.
                phase_len = 60;
                hold_requests++;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 1) == 1) begin
                push_load(fcm_pkg::IDX_W'($urandom_range(0, fcm_pkg::MAX_TAPS - 1)),
                          rand_word());
            end
            for (int i = 0; i < phase_len; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    push_load(fcm_pkg::IDX_W'($urandom_range(0, fcm_pkg::MAX_TAPS - 1)),
                              rand_word());
                end else begin
                    push_sample(rand_word());
                end
            end
            phase++;
        end

        settle_idle();
        repeat (300) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/fcm_pkg.sv
rtl/fcm_ram.sv
rtl/fcm_mac.sv
rtl/fir_filter_circular_mac_unit.sv
test/tb_fir_filter_circular_mac_unit.sv
